>>> rtl/tqcr_pkg.sv
// ----------------------------------------------------------------------------
// tqcr_pkg
// Shared types and constants for the two-queue cache replacement block.
// ----------------------------------------------------------------------------
package tqcr_pkg;

  // Width of the cache size register
  localparam int CFG_W = 7;
  // Reset value of the cache size register
  localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;
  // Smallest usable cache size
  localparam logic [CFG_W-1:0] MIN_SIZE = 7'd5;

  // Region codes of a slot
  typedef enum logic [1:0] {
    RG_EMPTY = 2'd0,
    RG_IN    = 2'd1,
    RG_OUT   = 2'd2,
    RG_HOT   = 2'd3
  } region_t;

  // Controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_DECIDE,
    ST_EVICT_OUT,
    ST_MOVE_IN,
    ST_INSERT,
    ST_EVICT_HOT,
    ST_PROMOTE,
    ST_TOUCH,
    ST_DONE
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic load_key;
    logic lookup;
    logic evict_out;
    logic move_in;
    logic insert;
    logic evict_hot;
    logic promote;
    logic touch;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic    hit;
    region_t region;
    logic    in_full;
    logic    out_full;
    logic    hot_full;
  } status_t;

endpackage

>>> rtl/tqcr_ctrl.sv
// ----------------------------------------------------------------------------
// tqcr_ctrl
// Sequencer: steps one transaction through lookup and region updates.
// ----------------------------------------------------------------------------
module tqcr_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  tqcr_pkg::status_t stat,
  output tqcr_pkg::cmd_t   cmd,
  output logic             busy,
  output logic             out_valid
);
  import tqcr_pkg::*;

  state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = 1'b1;
    out_valid = 1'b0;
    case (state_r)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load_key = 1'b1;
          state_nxt    = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        cmd.lookup = 1'b1;
        state_nxt  = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (!stat.hit) begin
          if (stat.in_full && stat.out_full) begin
            state_nxt = ST_EVICT_OUT;
          end else if (stat.in_full) begin
            state_nxt = ST_MOVE_IN;
          end else begin
            state_nxt = ST_INSERT;
          end
        end else begin
          case (stat.region)
            RG_OUT:  state_nxt = stat.hot_full ? ST_EVICT_HOT : ST_PROMOTE;
            RG_HOT:  state_nxt = ST_TOUCH;
            default: state_nxt = ST_DONE;
          endcase
        end
      end
      ST_EVICT_OUT: begin
        cmd.evict_out = 1'b1;
        state_nxt     = ST_MOVE_IN;
      end
      ST_MOVE_IN: begin
        cmd.move_in = 1'b1;
        state_nxt   = ST_INSERT;
      end
      ST_INSERT: begin
        cmd.insert = 1'b1;
        state_nxt  = ST_DONE;
      end
      ST_EVICT_HOT: begin
        cmd.evict_hot = 1'b1;
        state_nxt     = ST_PROMOTE;
      end
      ST_PROMOTE: begin
        cmd.promote = 1'b1;
        state_nxt   = ST_DONE;
      end
      ST_TOUCH: begin
        cmd.touch = 1'b1;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        out_valid = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/tqcr_dpath.sv
// ----------------------------------------------------------------------------
// tqcr_dpath
// Slot array with parallel key compare and per-slot region and age update.
// ----------------------------------------------------------------------------
module tqcr_dpath #(
  parameter int MAX_ENTRIES = 64,
  parameter int KEY_BITS    = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [tqcr_pkg::CFG_W-1:0]  cfg_wdata,
  input  logic [KEY_BITS-1:0]         key,
  input  tqcr_pkg::cmd_t              cmd,
  output tqcr_pkg::status_t           stat
);
  import tqcr_pkg::*;

  localparam int AGE_W = $clog2(MAX_ENTRIES);
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int CW    = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam logic [CW-1:0] MAX_C = CW'(MAX_ENTRIES);

  logic [CFG_W-1:0]    size_r;
  logic [KEY_BITS-1:0] key_r;
  logic [KEY_BITS-1:0] slot_key_r [MAX_ENTRIES];
  region_t             slot_reg_r [MAX_ENTRIES];
  logic [AGE_W-1:0]    slot_age_r [MAX_ENTRIES];
  logic [CNT_W-1:0]    in_cnt_r, out_cnt_r, hot_cnt_r;
  logic [MAX_ENTRIES-1:0] match_r;
  logic                hit_r;
  region_t             freg_r;
  logic [AGE_W-1:0]    fage_r;

  logic [CW-1:0]       sz_ext;
  logic [CFG_W-1:0]    esz, fifth, out_size;
  logic [MAX_ENTRIES-1:0] match, ins_sel;
  logic                taken;
  logic [1:0]          freg_or;
  logic [AGE_W-1:0]    fage_or;

  // Clamp size and split into regions; divide by five via reciprocal
  always_comb begin
    sz_ext = CW'(size_r);
    if (sz_ext < CW'(MIN_SIZE)) sz_ext = CW'(MIN_SIZE);
    if (sz_ext > MAX_C) sz_ext = MAX_C;
    esz      = sz_ext[CFG_W-1:0];
    fifth    = CFG_W'((15'(esz) * 15'd205) >> 10);
    out_size = esz - {fifth[CFG_W-2:0], 1'b0};
  end

  // Parallel compare and found-slot region and age
  always_comb begin
    freg_or = '0;
    fage_or = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      match[i] = (slot_reg_r[i] != RG_EMPTY) && (slot_key_r[i] == key_r);
      if (match[i]) begin
        freg_or = freg_or | slot_reg_r[i];
        fage_or = fage_or | slot_age_r[i];
      end
    end
  end

  // Pick one empty slot for insertion
  always_comb begin
    taken = 1'b0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      ins_sel[i] = (slot_reg_r[i] == RG_EMPTY) && !taken;
      taken      = taken | (slot_reg_r[i] == RG_EMPTY);
    end
  end

  // Status to the controller
  always_comb begin
    stat.hit      = hit_r;
    stat.region   = freg_r;
    stat.in_full  = CW'(in_cnt_r) >= CW'(fifth);
    stat.out_full = CW'(out_cnt_r) >= CW'(out_size);
    stat.hot_full = CW'(hot_cnt_r) >= CW'(fifth);
  end

  // Key and lookup results
  always_ff @(posedge clk) begin
    if (cmd.load_key) key_r <= key;
    if (cmd.lookup) begin
      match_r <= match;
      hit_r   <= |match;
      freg_r  <= region_t'(freg_or);
      fage_r  <= fage_or;
    end
  end

  // Size register and occupancy counts
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r    <= CFG_RESET;
      in_cnt_r  <= '0;
      out_cnt_r <= '0;
      hot_cnt_r <= '0;
    end else if (cfg_we) begin
      size_r    <= cfg_wdata;
      in_cnt_r  <= '0;
      out_cnt_r <= '0;
      hot_cnt_r <= '0;
    end else begin
      if (cmd.evict_out) out_cnt_r <= out_cnt_r - 1'b1;
      if (cmd.move_in) begin
        in_cnt_r  <= in_cnt_r - 1'b1;
        out_cnt_r <= out_cnt_r + 1'b1;
      end
      if (cmd.insert && taken) in_cnt_r <= in_cnt_r + 1'b1;
      if (cmd.evict_hot) hot_cnt_r <= hot_cnt_r - 1'b1;
      if (cmd.promote) begin
        out_cnt_r <= out_cnt_r - 1'b1;
        hot_cnt_r <= hot_cnt_r + 1'b1;
      end
    end
  end

  // Slot regions: cleared on reset and on a size write
  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (!rst_n || cfg_we) begin
        slot_reg_r[i] <= RG_EMPTY;
      end else if (cmd.evict_out) begin
        if (slot_reg_r[i] == RG_OUT && CNT_W'(slot_age_r[i]) == out_cnt_r - 1'b1)
          slot_reg_r[i] <= RG_EMPTY;
      end else if (cmd.move_in) begin
        if (slot_reg_r[i] == RG_IN && CNT_W'(slot_age_r[i]) == in_cnt_r - 1'b1)
          slot_reg_r[i] <= RG_OUT;
      end else if (cmd.insert) begin
        if (ins_sel[i]) slot_reg_r[i] <= RG_IN;
      end else if (cmd.evict_hot) begin
        if (slot_reg_r[i] == RG_HOT && CNT_W'(slot_age_r[i]) == hot_cnt_r - 1'b1)
          slot_reg_r[i] <= RG_EMPTY;
      end else if (cmd.promote) begin
        if (match_r[i]) slot_reg_r[i] <= RG_HOT;
      end
    end
  end

  // Slot keys and ages: queue shifts done in parallel
  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (cmd.move_in) begin
        if (slot_reg_r[i] == RG_IN && CNT_W'(slot_age_r[i]) == in_cnt_r - 1'b1)
          slot_age_r[i] <= '0;
        else if (slot_reg_r[i] == RG_OUT)
          slot_age_r[i] <= slot_age_r[i] + 1'b1;
      end else if (cmd.insert) begin
        if (ins_sel[i]) begin
          slot_key_r[i] <= key_r;
          slot_age_r[i] <= '0;
        end else if (slot_reg_r[i] == RG_IN) begin
          slot_age_r[i] <= slot_age_r[i] + 1'b1;
        end
      end else if (cmd.promote) begin
        if (match_r[i])
          slot_age_r[i] <= '0;
        else if (slot_reg_r[i] == RG_OUT && slot_age_r[i] > fage_r)
          slot_age_r[i] <= slot_age_r[i] - 1'b1;
        else if (slot_reg_r[i] == RG_HOT)
          slot_age_r[i] <= slot_age_r[i] + 1'b1;
      end else if (cmd.touch) begin
        if (match_r[i])
          slot_age_r[i] <= '0;
        else if (slot_reg_r[i] == RG_HOT && slot_age_r[i] < fage_r)
          slot_age_r[i] <= slot_age_r[i] + 1'b1;
      end
    end
  end

endmodule

>>> rtl/two_queue_cache_replacement.sv
// ----------------------------------------------------------------------------
// two_queue_cache_replacement
// Simplified 2Q cache lookup: in/out FIFOs and a hot LRU region.
// ----------------------------------------------------------------------------
// Sequence: after the accepting edge the controller steps through LOOKUP and
// DECIDE, then the queue-update steps that a miss or an out or hot hit needs
// (none on an in-region hit), then DONE, where out_valid is high.
// A new lookup is taken only once the current one is done; busy stays high through
// out_valid. Reset: synchronous; empties all regions and sets the size to 64.
// The receiver cannot stall; each result shows for one cycle.
module two_queue_cache_replacement #(
  parameter int MAX_ENTRIES = 64,
  parameter int KEY_BITS    = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [KEY_BITS-1:0]        in_lookup_key,
  output logic                       out_valid,
  output logic                       out_hit,
  output logic [1:0]                 out_found_region,
  input  logic                       cfg_we,
  input  logic [tqcr_pkg::CFG_W-1:0] cfg_wdata
);
  import tqcr_pkg::*;

  cmd_t    cmd;
  status_t stat;

  // Sequencer
  tqcr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  // Slot store
  tqcr_dpath #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .KEY_BITS    (KEY_BITS)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .key       (in_lookup_key),
    .cmd       (cmd),
    .stat      (stat)
  );

  // Drive result fields from held lookup status
  assign out_hit          = stat.hit;
  assign out_found_region = stat.region;

endmodule

>>> tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for two_queue_cache_replacement: a queue-fed driver sends
// lookup keys, a per-transaction 2Q predictor computes hit and region, and a
// monitor compares each strobed result with the oldest expected one.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tqcr_pkg::*;

  localparam int NSLOT = 64;

  logic        clk;
  logic        rst_n;
  logic        start = 1'b0;
  logic        busy;
  logic [31:0] in_lookup_key = '0;
  logic        out_valid;
  logic        out_hit;
  logic [1:0]  out_found_region;
  logic        cfg_we;
  logic [CFG_W-1:0] cfg_wdata;

  two_queue_cache_replacement #(.MAX_ENTRIES(NSLOT), .KEY_BITS(32)) DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_lookup_key(in_lookup_key), .out_valid(out_valid), .out_hit(out_hit),
    .out_found_region(out_found_region), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  typedef struct packed {
    logic    hit;
    region_t region;
  } lookup_res_t;

  // Predictor state: a shadow of the slot store
  logic [31:0] shadow_key [NSLOT];
  region_t     shadow_rg  [NSLOT];
  int          shadow_age [NSLOT];
  int          cnt_in, cnt_out, cnt_hot;
  int          size_eff;

  logic [31:0] key_queue [$];
  lookup_res_t result_queue [$];
  int          sender_idle_pct;
  int          errors, mismatches, lookups_done, hits_seen, misses_seen;
  int          configs_done;
  logic        busy_at_edge;

  // Clock
  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  function automatic void clear_shadow(int sz);
    size_eff = (sz < MIN_SIZE) ? MIN_SIZE : ((sz > NSLOT) ? NSLOT : sz);
    for (int i = 0; i < NSLOT; i++) begin
      shadow_rg[i]  = RG_EMPTY;
      shadow_age[i] = 0;
    end
    cnt_in = 0; cnt_out = 0; cnt_hot = 0;
  endfunction

  function automatic int oldest_slot(region_t rg);
    int best;
    best = -1;
    for (int i = 0; i < NSLOT; i++)
      if (shadow_rg[i] == rg && (best < 0 || shadow_age[i] > shadow_age[best]))
        best = i;
    return best;
  endfunction

  function automatic void detach(int s);
    for (int j = 0; j < NSLOT; j++)
      if (j != s && shadow_rg[j] == shadow_rg[s] && shadow_age[j] > shadow_age[s])
        shadow_age[j]--;
    shadow_rg[s] = RG_EMPTY;
  endfunction

  function automatic void to_head(int s, region_t rg);
    for (int j = 0; j < NSLOT; j++)
      if (shadow_rg[j] == rg) shadow_age[j]++;
    shadow_rg[s]  = rg;
    shadow_age[s] = 0;
  endfunction

  // Predict one lookup and update the shadow store
  function automatic lookup_res_t predict_lookup(logic [31:0] key);
    lookup_res_t r;
    int found, v, part;
    found = -1;
    part  = size_eff / 5;
    for (int i = 0; i < NSLOT; i++)
      if (found < 0 && shadow_rg[i] != RG_EMPTY && shadow_key[i] == key) found = i;
    if (found < 0) begin
      if (cnt_in >= part) begin
        if (cnt_out >= size_eff - 2 * part) begin
          v = oldest_slot(RG_OUT);
          if (v >= 0) begin detach(v); cnt_out--; end
        end
        v = oldest_slot(RG_IN);
        if (v >= 0) begin
          detach(v); cnt_in--;
          to_head(v, RG_OUT); cnt_out++;
        end
      end
      for (int i = 0; i < NSLOT; i++)
        if (shadow_rg[i] == RG_EMPTY) begin
          shadow_key[i] = key;
          to_head(i, RG_IN);
          cnt_in++;
          break;
        end
      r.hit = 1'b0; r.region = RG_EMPTY;
      return r;
    end
    r.hit = 1'b1;
    r.region = shadow_rg[found];
    if (r.region == RG_OUT) begin
      if (cnt_hot >= part) begin
        v = oldest_slot(RG_HOT);
        if (v >= 0) begin detach(v); cnt_hot--; end
      end
      detach(found); cnt_out--;
      to_head(found, RG_HOT); cnt_hot++;
    end else if (r.region == RG_HOT) begin
      detach(found);
      to_head(found, RG_HOT);
    end
    return r;
  endfunction

  // Driver: present the next key at the falling edge; on accept send the next key or drop start
  always @(negedge clk) begin
    if (rst_n && !cfg_we) begin
      if (start && !busy_at_edge) begin
        if (key_queue.size() > 0 && $urandom_range(99, 0) >= sender_idle_pct) begin
          in_lookup_key <= key_queue.pop_front();
        end else begin
          start <= 1'b0;
        end
      end else if (!start && key_queue.size() > 0 &&
                   $urandom_range(99, 0) >= sender_idle_pct) begin
        in_lookup_key <= key_queue.pop_front();
        start <= 1'b1;
      end
    end
  end

  // Accept detection: a transaction is taken when start is high and busy low
  always @(posedge clk) begin
    busy_at_edge <= busy;
    if (rst_n && start && !busy) begin
      result_queue.push_back(predict_lookup(in_lookup_key));
    end
  end

  // Monitor: compare each strobed result with the oldest expectation
  always @(posedge clk) begin
    lookup_res_t exp_r;
    if (rst_n && out_valid) begin
      if (result_queue.size() == 0) begin
        errors++;
        if (mismatches < 10) $display("unexpected result hit=%0b region=%0d",
                                      out_hit, out_found_region);
        mismatches++;
      end else begin
        exp_r = result_queue.pop_front();
        lookups_done++;
        if (exp_r.hit) hits_seen++; else misses_seen++;
        if (out_hit !== exp_r.hit || out_found_region !== exp_r.region) begin
          errors++;
          if (mismatches < 10)
            $display("mismatch #%0d: expected hit=%0b region=%0d got hit=%0b region=%0d",
                     lookups_done, exp_r.hit, exp_r.region, out_hit, out_found_region);
          mismatches++;
        end
      end
    end
  end

  // Wait until every queued key is taken and every result is back
  task automatic drain();
    while (key_queue.size() > 0 || start || result_queue.size() > 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  // Write the size register while idle; the shadow store empties with it
  task automatic write_size(logic [CFG_W-1:0] sz);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= sz;
    @(negedge clk);
    cfg_we    <= 1'b0;
    clear_shadow(sz);
    configs_done++;
  endtask

  // Well-formed traffic: keys drawn from a small working set so every region fills
  task automatic queue_working_set(int n, int span);
    logic [31:0] base;
    base = $urandom();
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9, 0) == 0) key_queue.push_back($urandom());
      else key_queue.push_back(base ^ $urandom_range(span - 1, 0));
    end
  endtask

  initial begin
    logic [CFG_W-1:0] sizes [6];
    sizes = '{7'd0, 7'd5, 7'd12, 7'd64, 7'd127, 7'd33};
    cfg_we = 1'b0; cfg_wdata = CFG_RESET;
    errors = 0; mismatches = 0; lookups_done = 0; hits_seen = 0; misses_seen = 0;
    configs_done = 0;
    sender_idle_pct = 0;
    clear_shadow(CFG_RESET);
    rst_n = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: key extremes and an in-region hit at size 64
    key_queue.push_back(32'h0000_0000);
    key_queue.push_back(32'hFFFF_FFFF);
    key_queue.push_back(32'h0000_0000);
    key_queue.push_back(32'hAAAA_AAAA);
    key_queue.push_back(32'h5555_5555);
    drain();
    // Smallest size: one in, three out, one hot; walk keys through all regions
    write_size(7'd3);
    for (int k = 1; k <= 6; k++) key_queue.push_back(k);
    key_queue.push_back(32'd3);
    key_queue.push_back(32'd4);
    key_queue.push_back(32'd4);
    key_queue.push_back(32'd5);
    key_queue.push_back(32'd1);
    key_queue.push_back(32'd6);
    key_queue.push_back(32'd7);
    key_queue.push_back(32'd6);
    drain();

    // Random phases across sizes and idle patterns
    for (int p = 0; p < 6; p++) begin
      write_size(sizes[p]);
      sender_idle_pct = (p < 2) ? 35 : ((p < 4) ? 63 : 0);
      queue_working_set(150, (p % 2) ? 16 : 96);
      drain();
    end

    $display("Covered %0d lookups (%0d hits, %0d misses) over %0d size settings.",
             lookups_done, hits_seen, misses_seen, configs_done);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Run limit
  initial begin
    #5ms;
    $display("Some tests failed");
    $finish;
  end

endmodule
